### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands clocked on clk, disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge of clk outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds at a rising edge of clk outside reset
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

### hdl/zcdp_pkg.sv
// ----------------------------------------------------------------------------
// zcdp_pkg
// Shared types and constants of the ZIP central directory parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package zcdp_pkg;

    localparam int          HDR_LEN   = 46;
    localparam logic [31:0] SIGNATURE = 32'h0201_4b50;

    // Byte offsets inside the fixed entry header
    localparam int FLAGS_AT    = 8;
    localparam int METHOD_AT   = 10;
    localparam int CRC_AT      = 16;
    localparam int PACKED_AT   = 20;
    localparam int PLAIN_AT    = 24;
    localparam int NAME_LEN_AT = 28;
    localparam int EXTRA_AT    = 30;
    localparam int COMMENT_AT  = 32;
    localparam int OFFSET_AT   = 42;

    // Result kinds
    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_NAME   = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;
    localparam logic [1:0] KIND_DONE   = 2'd3;

    // Error codes
    localparam logic [1:0] ERR_SIGNATURE = 2'd0;
    localparam logic [1:0] ERR_OVERRUN   = 2'd1;
    localparam logic [1:0] ERR_TRUNCATED = 2'd2;

    // Configuration register indexes
    localparam logic CFG_ENTRY_TOTAL = 1'b0;
    localparam logic CFG_DIR_SIZE    = 1'b1;

    localparam int TDATA_W = 208;

    typedef struct packed {
        logic [23:0] sig_low;
        logic [15:0] flag_bits;
        logic [15:0] method;
        logic [31:0] crc_value;
        logic [31:0] packed_size;
        logic [31:0] plain_size;
        logic [15:0] name_len;
        logic [15:0] extra_len;
        logic [15:0] comment_len;
        logic [23:0] offset_low;
    } hdr_fields_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] entry_index;
        logic [31:0] crc_value;
        logic [31:0] packed_size;
        logic [31:0] plain_size;
        logic [15:0] method;
        logic [15:0] flag_bits;
        logic [31:0] header_offset;
        logic [15:0] name_length;
        logic [7:0]  name_char;
        logic [1:0]  error_code;
    } res_t;

    typedef struct packed {
        logic stopped;
        logic in_header;
    } seq_status_t;

endpackage

### hdl/zcdp_header_store.sv
// ----------------------------------------------------------------------------
// zcdp_header_store
// Byte store for the 46-byte fixed entry header, with field decode.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module zcdp_header_store
    import zcdp_pkg::*;
(
    input  logic        clk,
    input  logic        wr_en,
    input  logic [5:0]  wr_addr,
    input  logic [7:0]  wr_byte,
    output hdr_fields_t fields
);

    logic [7:0] hdr_reg [HDR_LEN];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            hdr_reg[wr_addr] <= wr_byte;
        end
    end

    assign fields.sig_low     = {hdr_reg[2], hdr_reg[1], hdr_reg[0]};
    assign fields.flag_bits   = {hdr_reg[FLAGS_AT + 1], hdr_reg[FLAGS_AT]};
    assign fields.method      = {hdr_reg[METHOD_AT + 1], hdr_reg[METHOD_AT]};
    assign fields.crc_value   = {hdr_reg[CRC_AT + 3], hdr_reg[CRC_AT + 2],
                                 hdr_reg[CRC_AT + 1], hdr_reg[CRC_AT]};
    assign fields.packed_size = {hdr_reg[PACKED_AT + 3], hdr_reg[PACKED_AT + 2],
                                 hdr_reg[PACKED_AT + 1], hdr_reg[PACKED_AT]};
    assign fields.plain_size  = {hdr_reg[PLAIN_AT + 3], hdr_reg[PLAIN_AT + 2],
                                 hdr_reg[PLAIN_AT + 1], hdr_reg[PLAIN_AT]};
    assign fields.name_len    = {hdr_reg[NAME_LEN_AT + 1], hdr_reg[NAME_LEN_AT]};
    assign fields.extra_len   = {hdr_reg[EXTRA_AT + 1], hdr_reg[EXTRA_AT]};
    assign fields.comment_len = {hdr_reg[COMMENT_AT + 1], hdr_reg[COMMENT_AT]};
    // top offset byte arrives with the last header byte and is not read here
    assign fields.offset_low  = {hdr_reg[OFFSET_AT + 2], hdr_reg[OFFSET_AT + 1],
                                 hdr_reg[OFFSET_AT]};

endmodule

### hdl/zcdp_sequencer.sv
// ----------------------------------------------------------------------------
// zcdp_sequencer
// Per-byte record walker: header, name and skip phases, entry bookkeeping.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module zcdp_sequencer
    import zcdp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    input  logic [15:0] entry_total,
    input  logic [31:0] dir_size,
    input  hdr_fields_t fields,
    output logic        hdr_wr,
    output logic [5:0]  hdr_addr,
    output logic        res_valid,
    output res_t        res,
    output seq_status_t status
);

    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_NAME   = 2'd1;
    localparam logic [1:0] PH_SKIP   = 2'd2;
    localparam logic [1:0] PH_STOP   = 2'd3;

    logic [1:0]  phase_reg, phase_next;
    logic [17:0] bir_reg, bir_next;
    logic [15:0] seen_reg, seen_next;
    logic [32:0] pos_reg, pos_next;
    logic [17:0] skip_reg, skip_next;

    logic [17:0] bir_inc;
    logic [17:0] skip_dec;
    logic [17:0] name_end;
    logic [33:0] end_sum;
    logic        made;
    logic        rec_done;
    logic        hard_err;
    logic        complete_now;
    logic        complete_after;

    assign hdr_addr = bir_reg[5:0];
    assign bir_inc  = bir_reg + 18'd1;
    assign skip_dec = (skip_reg != 18'd0) ? skip_reg - 18'd1 : skip_reg;
    assign name_end = 18'(HDR_LEN) + 18'(fields.name_len);
    assign end_sum  = 34'(pos_reg) + 34'(HDR_LEN) + 34'(fields.name_len)
                    + 34'(fields.extra_len) + 34'(fields.comment_len);
    assign complete_now = (phase_reg == PH_HEADER) && (bir_reg == 18'd0)
                       && (seen_reg >= entry_total);

    assign status.stopped   = (phase_reg == PH_STOP);
    assign status.in_header = (phase_reg == PH_HEADER);

    always_comb
    begin
        phase_next     = phase_reg;
        bir_next       = bir_reg;
        seen_next      = seen_reg;
        pos_next       = pos_reg;
        skip_next      = skip_reg;
        hdr_wr         = 1'b0;
        res_valid      = 1'b0;
        res            = '0;
        res.entry_index = seen_reg;
        made           = 1'b0;
        rec_done       = 1'b0;
        hard_err       = 1'b0;
        complete_after = 1'b0;

        if (step && (phase_reg != PH_STOP))
        begin
            if (complete_now)
            begin
                res_valid  = 1'b1;
                res.kind   = KIND_DONE;
                phase_next = PH_STOP;
            end
            else
            begin
                unique case (phase_reg)
                    PH_HEADER:
                    begin
                        hdr_wr   = 1'b1;
                        bir_next = bir_inc;
                        if ((bir_inc == 18'd4) && ({data_byte, fields.sig_low} != SIGNATURE))
                        begin
                            hard_err       = 1'b1;
                            res_valid      = 1'b1;
                            res.kind       = KIND_ERROR;
                            res.error_code = ERR_SIGNATURE;
                            phase_next     = PH_STOP;
                        end
                        else if (bir_inc == 18'(HDR_LEN))
                        begin
                            if (end_sum > 34'(dir_size))
                            begin
                                hard_err       = 1'b1;
                                res_valid      = 1'b1;
                                res.kind       = KIND_ERROR;
                                res.error_code = ERR_OVERRUN;
                                phase_next     = PH_STOP;
                            end
                            else
                            begin
                                made              = 1'b1;
                                res.kind          = KIND_HEADER;
                                res.crc_value     = fields.crc_value;
                                res.packed_size   = fields.packed_size;
                                res.plain_size    = fields.plain_size;
                                res.method        = fields.method;
                                res.flag_bits     = fields.flag_bits;
                                res.header_offset = {data_byte, fields.offset_low};
                                res.name_length   = fields.name_len;
                                skip_next = 18'(fields.extra_len) + 18'(fields.comment_len);
                                if (fields.name_len != 16'd0)
                                begin
                                    phase_next = PH_NAME;
                                end
                                else if (skip_next != 18'd0)
                                begin
                                    phase_next = PH_SKIP;
                                end
                                else
                                begin
                                    rec_done = 1'b1;
                                end
                            end
                        end
                    end
                    PH_NAME:
                    begin
                        made          = 1'b1;
                        res.kind      = KIND_NAME;
                        res.name_char = data_byte;
                        bir_next      = bir_inc;
                        if (bir_inc >= name_end)
                        begin
                            if (skip_reg != 18'd0)
                            begin
                                phase_next = PH_SKIP;
                            end
                            else
                            begin
                                rec_done = 1'b1;
                            end
                        end
                    end
                    PH_SKIP:
                    begin
                        bir_next  = bir_inc;
                        skip_next = skip_dec;
                        if (skip_dec == 18'd0)
                        begin
                            rec_done = 1'b1;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_STOP;
                    end
                endcase

                if (rec_done)
                begin
                    seen_next  = seen_reg + 16'd1;
                    pos_next   = pos_reg + 33'(bir_inc);
                    bir_next   = 18'd0;
                    phase_next = PH_HEADER;
                end

                if (!hard_err)
                begin
                    complete_after = (phase_next == PH_HEADER) && (bir_next == 18'd0)
                                  && (seen_next >= entry_total);
                    if (last_byte && !complete_after)
                    begin
                        res             = '0;
                        res_valid       = 1'b1;
                        res.kind        = KIND_ERROR;
                        res.entry_index = seen_next;
                        res.error_code  = ERR_TRUNCATED;
                        phase_next      = PH_STOP;
                    end
                    else if (!made && complete_after)
                    begin
                        res             = '0;
                        res_valid       = 1'b1;
                        res.kind        = KIND_DONE;
                        res.entry_index = seen_next;
                        phase_next      = PH_STOP;
                    end
                    else
                    begin
                        res_valid = made;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            bir_reg   <= '0;
            seen_reg  <= '0;
            pos_reg   <= '0;
            skip_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            bir_reg   <= bir_next;
            seen_reg  <= seen_next;
            pos_reg   <= pos_next;
            skip_reg  <= skip_next;
        end
    end

endmodule

### hdl/zcdp_out_stage.sv
// ----------------------------------------------------------------------------
// zcdp_out_stage
// Result register between the sequencer and the master stream side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module zcdp_out_stage
    import zcdp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  res_t in_res,
    output logic can_load,
    input  logic out_ready,
    output logic out_valid,
    output res_t out_res
);

    logic valid_reg, valid_next;
    res_t res_reg;

    // free, or emptied by the sink in this cycle
    assign can_load   = !valid_reg || out_ready;
    assign valid_next = can_load ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (can_load && in_valid)
        begin
            res_reg <= in_res;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

### hdl/zip_central_directory_parser.sv
// ----------------------------------------------------------------------------
// zip_central_directory_parser
// Byte-stream walker of a ZIP central directory: entry descriptors, name
// bytes, done and error reports.
// ----------------------------------------------------------------------------
// Feed the central directory one byte per transaction, starting at its first
// byte, with s_tlast on the final byte present in the archive. The block takes
// one byte every clock cycle: each byte updates the record counters and the
// header byte store in the same cycle, and its result, if any, lands in a
// single output register. Input stalls only while that register holds a result
// the sink has not taken. Per entry the block returns one descriptor (after
// the 46th header byte), then one transaction per file-name byte; extra-field
// and comment bytes produce nothing. After entry_total entries a done result
// follows, on the byte that closes the last entry if it carries no other
// result, else on the next byte. A bad signature, an entry ending past
// dir_size, or s_tlast before the directory is complete produces one error
// result. After done or an error all further bytes are taken and dropped until
// reset. Write the configuration registers only while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module zip_central_directory_parser
    import zcdp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // configuration write port: index 0 entry_total, index 1 dir_size
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [31:0]        cfg_data,
    // input stream
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,    // [7:0] data_byte
    input  logic               s_tlast,    // last_byte
    // result stream
    output logic               m_tvalid,
    input  logic               m_tready,
    // [15:0] entry_index, [47:16] crc_value, [79:48] packed_size,
    // [111:80] plain_size, [127:112] method, [143:128] flag_bits,
    // [175:144] header_offset, [191:176] name_length, [199:192] name_char,
    // [201:200] error_code, [207:202] zero
    output logic [TDATA_W-1:0] m_tdata,
    output logic [1:0]         m_tuser     // [1:0] kind
);

    logic [15:0] entry_total_reg;
    logic [31:0] dir_size_reg;

    logic        step;
    logic        can_load;
    logic        hdr_wr;
    logic [5:0]  hdr_addr;
    logic        res_valid;
    res_t        res;
    res_t        out_res;
    hdr_fields_t fields;
    seq_status_t status;

    // Configuration registers; unknown index cannot occur on a one-bit index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_total_reg <= '0;
            dir_size_reg    <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ENTRY_TOTAL: entry_total_reg <= cfg_data[15:0];
                CFG_DIR_SIZE:    dir_size_reg    <= cfg_data;
                default:         ;
            endcase
        end
    end

    // Accept a byte whenever the result register can take this cycle's result
    assign s_tready = can_load;
    assign step     = s_tvalid && can_load;

    zcdp_header_store u_store (
        .clk     (clk),
        .wr_en   (hdr_wr),
        .wr_addr (hdr_addr),
        .wr_byte (s_tdata),
        .fields  (fields)
    );

    zcdp_sequencer u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .data_byte   (s_tdata),
        .last_byte   (s_tlast),
        .entry_total (entry_total_reg),
        .dir_size    (dir_size_reg),
        .fields      (fields),
        .hdr_wr      (hdr_wr),
        .hdr_addr    (hdr_addr),
        .res_valid   (res_valid),
        .res         (res),
        .status      (status)
    );

    zcdp_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (res_valid),
        .in_res    (res),
        .can_load  (can_load),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_res   (out_res)
    );

    // Pack the result fields, lowest field first
    assign m_tuser = out_res.kind;
    assign m_tdata = {6'd0,
                      out_res.error_code,
                      out_res.name_char,
                      out_res.name_length,
                      out_res.header_offset,
                      out_res.flag_bits,
                      out_res.method,
                      out_res.plain_size,
                      out_res.packed_size,
                      out_res.crc_value,
                      out_res.entry_index};

    // Once stopped, the walker never restarts before reset
    `ASSERT_CLK(a_stop_sticks, status.stopped |=> status.stopped, "walker left stopped state")

    // A pending error or done result means the walker has stopped
    `ASSERT_CLK(a_final_stops, m_tvalid && (m_tuser == KIND_ERROR || m_tuser == KIND_DONE) |-> status.stopped, "final result while walker still running")

    // A descriptor carries no name byte and no error code
    `ASSERT_NEVER(a_hdr_clean, m_tvalid && m_tuser == KIND_HEADER && m_tdata[201:192] != 10'd0, "descriptor with stray name or error bits")

    // The header store is written only in the header phase
    `ASSERT_CLK(a_wr_in_header, hdr_wr |-> status.in_header && step, "header store written outside header phase")

endmodule
